// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int KEY_BITS       = 32;
    localparam int IN_TAG_BITS    = 16;
    localparam int OUT_TAG_BITS   = 16;
    localparam int FILL_BITS      = 7;
    localparam int FAULT_BITS     = 2;
    localparam int IN_TDATA_BITS  = 48;
    localparam int OUT_TDATA_BITS = 56;
    localparam int OUT_TUSER_BITS = 3;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [FAULT_BITS-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_BITS-1:0] FAULT_FULL  = 2'd1;
    localparam logic [FAULT_BITS-1:0] FAULT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        RES_INS_OK,
        RES_INS_FULL,
        RES_EXT_OK,
        RES_EXT_EMPTY
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      idx_top;
        logic      idx_dec;
        logic      rd_en;
        logic      rd_top;
        logic      wr_new;
        logic      wr_shift;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic idx_zero;
        logic less;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded min-first queue of (key, tag) entries; equal keys leave newest first.
//
// Input stream (s_axis): tuser is the op (insert or extract), tdata carries
// key and tag. Output stream (m_axis): one result transaction per input
// transaction, in order, with extracted tag and key, found and fault flags,
// and the entry count after the operation.
// After an input transaction is accepted, s_axis_tready stays low until the
// result is loaded. An extract or a faulted op goes straight to the result;
// an insert first walks from the tail toward the head, shifting each stored
// entry with a smaller key up by one, one entry per read/compare pair through
// the single-port-read entry RAM, and writes the new entry where it stops.
// The result is presented on m_axis in the cycle s_axis_tready returns.
// The result sits in an output register; a new transaction is accepted while
// it waits. When the receiver stalls, the next result holds in the sequencer
// until the output register frees up, and input accepts stop behind it.
// Reset empties the queue at once; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [31:0] key, [47:32] tag
    input  wire logic [spq_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    // [0] op
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [15:0] out_tag, [47:16] out_key, [54:48] fill, [55] zero
    output logic [spq_pkg::OUT_TDATA_BITS-1:0]        m_axis_tdata,
    // [0] found, [2:1] fault
    output logic [spq_pkg::OUT_TUSER_BITS-1:0]        m_axis_tuser
);

    import spq_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    logic [OUT_TAG_BITS-1:0] res_tag;
    logic [KEY_BITS-1:0]     res_key;
    logic                    res_found;
    logic [FAULT_BITS-1:0]   res_fault;
    logic [FILL_BITS-1:0]    res_fill;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    spq_dp #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (s_axis_tuser),
        .in_key    (signed'(s_axis_tdata[KEY_BITS-1:0])),
        .in_tag    (s_axis_tdata[KEY_BITS+IN_TAG_BITS-1:KEY_BITS]),
        .cmd       (cmd),
        .sts       (sts),
        .res_tag   (res_tag),
        .res_key   (res_key),
        .res_found (res_found),
        .res_fault (res_fault),
        .res_fill  (res_fill)
    );

    assign m_axis_tdata = {1'b0, res_fill, res_key, res_tag};
    assign m_axis_tuser = {res_fault, res_found};

`ifndef SYNTH
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous transaction in progress");

    a_found_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == FAULT_NONE))
        else $error("found result carries a fault code");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == FAULT_EMPTY)
        |-> (m_axis_tdata[54:48] == '0))
        else $error("extract on empty reports nonzero fill");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2:1] == FAULT_FULL)
        |-> (m_axis_tdata[54:48] == FILL_BITS'(DEPTH)))
        else $error("dropped insert reports fill other than capacity");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: dispatch, insertion walk from the tail, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire spq_pkg::sts_t sts,
    output spq_pkg::cmd_t      cmd
);

    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_CMP,
        S_FINISH
    } state_t;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;
    logic      out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_kind = kind_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.op == OP_INSERT)
                begin
                    if (sts.full)
                    begin
                        kind_next  = RES_INS_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        kind_next   = RES_INS_OK;
                        cmd.idx_top = 1'b1;
                        state_next  = S_WALK_RD;
                    end
                end
                else
                begin
                    if (sts.empty)
                    begin
                        kind_next = RES_EXT_EMPTY;
                    end
                    else
                    begin
                        kind_next  = RES_EXT_OK;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_top = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_WALK_RD:
            begin
                if (sts.idx_zero)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_WALK_CMP;
                end
            end
            S_WALK_CMP:
            begin
                if (sts.less)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.idx_dec  = 1'b1;
                    state_next   = S_WALK_RD;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= RES_INS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: entry count, walk index, entry RAM, key compare, result register.
// Entries are held largest key first; the smallest sits at index count-1.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_dp #(
    parameter int DEPTH    = 64,
    parameter int TAG_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_op,
    input  wire logic signed [spq_pkg::KEY_BITS-1:0]   in_key,
    input  wire logic [spq_pkg::IN_TAG_BITS-1:0]       in_tag,
    input  wire spq_pkg::cmd_t                         cmd,
    output spq_pkg::sts_t                              sts,
    output logic [spq_pkg::OUT_TAG_BITS-1:0]           res_tag,
    output logic [spq_pkg::KEY_BITS-1:0]               res_key,
    output logic                                       res_found,
    output logic [spq_pkg::FAULT_BITS-1:0]             res_fault,
    output logic [spq_pkg::FILL_BITS-1:0]              res_fill
);

    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_BITS + TAG_BITS;

    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic                       op_reg;
    logic signed [KEY_BITS-1:0] ent_key_reg;
    logic [TAG_BITS-1:0]        ent_tag_reg;

    logic [OUT_TAG_BITS-1:0]    res_tag_reg;
    logic [KEY_BITS-1:0]        res_key_reg;
    logic                       res_found_reg;
    logic [FAULT_BITS-1:0]      res_fault_reg;
    logic [FILL_BITS-1:0]       res_fill_reg;

    logic                       wr_en;
    logic [AW-1:0]              rd_addr;
    logic [EW-1:0]              wr_data;
    logic [EW-1:0]              rd_data;
    logic signed [KEY_BITS-1:0] rd_key;
    logic [TAG_BITS-1:0]        rd_tag;

    assign rd_key  = signed'(rd_data[KEY_BITS-1:0]);
    assign rd_tag  = rd_data[EW-1:KEY_BITS];
    assign rd_addr = cmd.rd_top ? AW'(count_reg - 1'b1) : (idx_reg - 1'b1);
    assign wr_en   = cmd.wr_new | cmd.wr_shift;
    assign wr_data = cmd.wr_shift ? rd_data : {ent_tag_reg, ent_key_reg};

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.res_load && cmd.res_kind == RES_INS_OK)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.res_load && cmd.res_kind == RES_EXT_OK)
        begin
            count_next = count_reg - 1'b1;
        end

        idx_next = idx_reg;
        if (cmd.idx_top)
        begin
            idx_next = AW'(count_reg);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_in)
        begin
            op_reg      <= in_op;
            ent_key_reg <= in_key;
            ent_tag_reg <= TAG_BITS'(in_tag);
        end
        if (cmd.res_load)
        begin
            res_fill_reg <= FILL_BITS'(count_next);
            case (cmd.res_kind)
                RES_EXT_OK:
                begin
                    res_tag_reg   <= OUT_TAG_BITS'(rd_tag);
                    res_key_reg   <= rd_key;
                    res_found_reg <= 1'b1;
                    res_fault_reg <= FAULT_NONE;
                end
                RES_INS_FULL:
                begin
                    res_tag_reg   <= '0;
                    res_key_reg   <= '0;
                    res_found_reg <= 1'b0;
                    res_fault_reg <= FAULT_FULL;
                end
                RES_EXT_EMPTY:
                begin
                    res_tag_reg   <= '0;
                    res_key_reg   <= '0;
                    res_found_reg <= 1'b0;
                    res_fault_reg <= FAULT_EMPTY;
                end
                default:
                begin
                    res_tag_reg   <= '0;
                    res_key_reg   <= '0;
                    res_found_reg <= 1'b0;
                    res_fault_reg <= FAULT_NONE;
                end
            endcase
        end
    end

    assign sts.op       = op_reg;
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.less     = (rd_key < ent_key_reg);

    assign res_tag   = res_tag_reg;
    assign res_key   = res_key_reg;
    assign res_found = res_found_reg;
    assign res_fault = res_fault_reg;
    assign res_fill  = res_fill_reg;

endmodule

`default_nettype wire

// File: tb/spq_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_result_check
// Watches both streams of the sorted priority queue, keeps its own sorted
// copy of the stored entries and compares every result transaction, field by
// field, with the one predicted when the matching input transaction was taken.
// ----------------------------------------------------------------------------

module spq_result_check #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [spq_pkg::IN_TDATA_BITS-1:0]    s_data,
    input  logic                                 s_user,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [spq_pkg::OUT_TDATA_BITS-1:0]   m_data,
    input  logic [spq_pkg::OUT_TUSER_BITS-1:0]   m_user,
    output int                                   pending,
    output int                                   failures
);
    import spq_pkg::*;

    typedef struct packed {
        logic [OUT_TAG_BITS-1:0]   tag;
        logic [KEY_BITS-1:0]       key;
        logic                      found;
        logic [FAULT_BITS-1:0]     fault;
        logic [FILL_BITS-1:0]      fill;
    } queue_result_t;

    logic signed [KEY_BITS-1:0]  model_keys [QUEUE_DEPTH];
    logic [IN_TAG_BITS-1:0]      model_tags [QUEUE_DEPTH];
    int                          model_count;
    queue_result_t               awaited_results [$];
    int                          fail_count;

    function automatic queue_result_t apply_queue_op(input logic op,
                                                     input logic signed [KEY_BITS-1:0] key,
                                                     input logic [IN_TAG_BITS-1:0] tag);
        queue_result_t r;
        int slot;
        r = '0;
        if (op == OP_INSERT) begin
            if (model_count >= QUEUE_DEPTH) begin
                r.fault = FAULT_FULL;
            end
            else begin
                slot = 0;
                while (slot < model_count && model_keys[slot] < key)
                    slot++;
                for (int i = model_count; i > slot; i--) begin
                    model_keys[i] = model_keys[i-1];
                    model_tags[i] = model_tags[i-1];
                end
                model_keys[slot] = key;
                model_tags[slot] = tag;
                model_count++;
            end
        end
        else begin
            if (model_count == 0) begin
                r.fault = FAULT_EMPTY;
            end
            else begin
                r.tag   = model_tags[0];
                r.key   = model_keys[0];
                r.found = 1'b1;
                for (int i = 1; i < model_count; i++) begin
                    model_keys[i-1] = model_keys[i];
                    model_tags[i-1] = model_tags[i];
                end
                model_count--;
            end
        end
        r.fill = FILL_BITS'(model_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        queue_result_t want;
        if (!rst_n) begin
            model_count = 0;
            fail_count  = 0;
            awaited_results.delete();
            pending  <= 0;
            failures <= 0;
        end
        else begin
            if (s_valid && s_ready)
                awaited_results.push_back(apply_queue_op(s_user, s_data[31:0], s_data[47:32]));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transaction with nothing outstanding: tdata 0x%0h",
                           m_data);
                    fail_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("out_tag", want.tag,   m_data[15:0]);
                    check_field("out_key", want.key,   m_data[47:16]);
                    check_field("fill",    want.fill,  m_data[54:48]);
                    check_field("pad",     1'b0,       m_data[55]);
                    check_field("found",   want.found, m_user[0]);
                    check_field("fault",   want.fault, m_user[2:1]);
                end
            end
            pending  <= awaited_results.size();
            failures <= fail_count;
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert and extract transactions into the sorted priority queue with
// random gaps and random back-pressure, and reports the outcome of the
// result checker: a directed opening (empty, extreme keys, ties), then
// phases that swing the queue between empty and full.
// ----------------------------------------------------------------------------

module testbench;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 76;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [IN_TDATA_BITS-1:0]    s_data = '0;
    logic                        s_user = OP_INSERT;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_data;
    logic [OUT_TUSER_BITS-1:0]   m_user;
    int                          pending;
    int                          failures;
    int                          cycle_count = 0;
    int unsigned                 rx_hold = 0;
    logic                        steady = 1'b0;

    sorted_priority_queue #(
        .DEPTH    (QUEUE_DEPTH),
        .TAG_BITS (IN_TAG_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    spq_result_check #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_result_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .s_user   (s_user),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .m_user   (m_user),
        .pending  (pending),
        .failures (failures)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: after each result transaction, may hold tready low, but never in steady phases
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int unsigned rx_gap;
        if (!rst_n)
        begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end
        else if (m_ready)
        begin
            if (m_valid)
            begin
                rx_gap = steady ? 0 : $urandom_range(0, 10);
                if (rx_gap != 0)
                begin
                    m_ready <= 1'b0;
                    rx_hold <= rx_gap - 1;
                end
            end
        end
        else if (rx_hold == 0)
            m_ready <= 1'b1;
        else
            rx_hold <= rx_hold - 1;
    end

    task automatic send_op(input logic op, input logic [KEY_BITS-1:0] key,
                           input logic [IN_TAG_BITS-1:0] tag);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {tag, key};
        do
            @(posedge clk);
        while (!s_ready);
    endtask

    // mostly ties around zero and full-range values, now and then the extremes
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return KEY_BITS'(int'($urandom_range(0, 6)) - 3);
            default: return $urandom();
        endcase
    endfunction

    function automatic int insert_percent(input int phase);
        case (phase)
            0: return 95;
            1: return 50;
            2: return 8;
            3: return 60;
            4: return 92;
            default: return 12;
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_EXTRACT, 32'h0000_0000, 16'h0000);
        send_op(OP_INSERT,  32'h7FFF_FFFF, 16'hFFFF);
        send_op(OP_INSERT,  32'h8000_0000, 16'h0000);
        send_op(OP_INSERT,  32'h0000_0000, 16'h1234);
        send_op(OP_INSERT,  32'hFFFF_FFFF, 16'h5555);
        send_op(OP_INSERT,  32'h0000_0000, 16'hAAAA);
        send_op(OP_INSERT,  32'h0000_0000, 16'h00FF);
        send_op(OP_INSERT,  32'h0001_0000, 16'h8000);
        repeat (7) send_op(OP_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(OP_EXTRACT, 32'h1234_5678, 16'h4321);
        send_op(OP_INSERT,  32'h7FFF_FFFF, 16'h0001);
        send_op(OP_INSERT,  32'h7FFF_FFFF, 16'h0002);
        send_op(OP_INSERT,  32'h8000_0000, 16'h0003);
        send_op(OP_INSERT,  32'h8000_0000, 16'h0004);
        repeat (5) send_op(OP_EXTRACT, 32'h0000_0000, 16'h0000);

        for (int p = 0; p < PHASES; p++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(1, 100) <= insert_percent(p))
                    send_op(OP_INSERT, pick_key(), IN_TAG_BITS'($urandom()));
                else
                    send_op(OP_EXTRACT, $urandom(), IN_TAG_BITS'($urandom()));
            end
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_dp.sv
hw/rtl/sorted_priority_queue.sv
tb/spq_result_check.sv
tb/testbench.sv
